[hw/rtl/assert_macros.svh]
// Assertion macros shared by the lattice swap energy RTL.
// Depends on nothing; the including module must have clock and reset signals.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LSED_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lsed assertion failed");

// Next-cycle implication, checked outside reset.
`define LSED_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lsed assertion failed");

`endif

[hw/rtl/lsed_pkg.sv]
// Package for the lattice swap energy block: types, codes and site functions.
// Depends on nothing; used by every module of the block.
package lsed_pkg;

   localparam int SIDE  = 16;
   localparam int CW    = 4;
   localparam int SITES = SIDE * SIDE * SIDE;
   localparam int AW    = $clog2(SITES);
   localparam int SPW   = 2;
   localparam int EW    = 5;
   localparam int SUMW  = 9;
   localparam int DW    = 10;
   localparam int PW    = 3;
   localparam logic [PW-1:0] POS_LAST = PW'(6);

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [2:0] DIR_MID_DN = 3'd0;
   localparam logic [2:0] DIR_MID_UP = 3'd1;
   localparam logic [2:0] DIR_INN_DN = 3'd2;
   localparam logic [2:0] DIR_INN_UP = 3'd3;
   localparam logic [2:0] DIR_OUT_DN = 3'd4;
   localparam logic [2:0] DIR_OUT_UP = 3'd5;

   localparam logic [SPW-1:0] SPC_EMPTY = 2'd0;
   localparam logic [SPW-1:0] SPC_ONE   = 2'd1;

   typedef logic [AW-1:0]  addr_type;
   typedef logic [SPW-1:0] spc_type;
   typedef logic [CW-1:0]  crd_type;

   typedef struct packed {
      crd_type outer;
      crd_type middle;
      crd_type inner;
   } coord_type;

   typedef struct packed {
      logic       command;
      crd_type    coord_outer;
      crd_type    coord_middle;
      crd_type    coord_inner;
      logic [2:0] direction;
      spc_type    species;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] energy_change;
      logic                 skipped;
   } rsp_type;

   typedef struct packed {
      logic     valid;
      logic     first;
      logic     last;
      addr_type addr;
   } tag_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_RD_A, ST_RD_B, ST_CHK, ST_CALC, ST_DRAIN, ST_FIN
   } state_type;

   function automatic crd_type wrap_dn(crd_type c);
      return (c == '0) ? CW'(SIDE - 1) : c - CW'(1);
   endfunction

   function automatic crd_type wrap_up(crd_type c);
      return (c == CW'(SIDE - 1)) ? '0 : c + CW'(1);
   endfunction

   function automatic coord_type nbr(coord_type c, logic [2:0] dir);
      coord_type r;
      r = c;
      unique case (dir)
         DIR_MID_DN: r.middle = wrap_dn(c.middle);
         DIR_MID_UP: r.middle = wrap_up(c.middle);
         DIR_INN_DN: r.inner  = wrap_dn(c.inner);
         DIR_INN_UP: r.inner  = wrap_up(c.inner);
         DIR_OUT_DN: r.outer  = wrap_dn(c.outer);
         default:    r.outer  = wrap_up(c.outer);
      endcase
      return r;
   endfunction

   // Position zero is the site itself, positions one to six its neighbors.
   function automatic coord_type pos_coord(coord_type c, logic [PW-1:0] pos);
      return (pos == '0) ? c : nbr(c, pos - PW'(1));
   endfunction

   function automatic addr_type site_addr(coord_type c);
      return AW'(c.inner) + AW'(SIDE) * AW'(c.middle) + AW'(SIDE * SIDE) * AW'(c.outer);
   endfunction

   function automatic logic [EW-1:0] site_energy(spc_type s, logic [PW-1:0] occ);
      logic signed [3:0] d;
      logic signed [7:0] sq;
      d  = $signed({1'b0, occ}) - ((s == SPC_ONE) ? 4'sd3 : 4'sd5);
      sq = d * d;
      return (s == SPC_EMPTY) ? '0 : sq[EW-1:0];
   endfunction

endpackage

[hw/rtl/lsed_store.sv]
// Lattice species memory: one write port, one registered read port.
// Depends on lsed_pkg.
module lsed_store import lsed_pkg::*; (
   input  logic     clock,
   input  logic     wr_en,
   input  addr_type wr_addr,
   input  spc_type  wr_data,
   input  addr_type rd_addr,
   output spc_type  rd_data
);

   spc_type mem [SITES];
   spc_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/lsed_accum.sv]
// Energy accumulator: turns the stream of site reads into before and after sums.
// Depends on lsed_pkg.
module lsed_accum import lsed_pkg::*; (
   input  logic            clock,
   input  logic            clr,
   input  tag_type         tag,
   input  spc_type         rd_data,
   input  addr_type        a_addr,
   input  addr_type        b_addr,
   input  spc_type         sa,
   input  spc_type         sb,
   output logic [SUMW-1:0] sum_before,
   output logic [SUMW-1:0] sum_after
);

   spc_type         cen_b_ff, cen_a_ff;
   logic [PW-1:0]   occ_b_ff, occ_a_ff;
   logic [SUMW-1:0] sum_b_ff, sum_a_ff;
   spc_type         aft;
   logic [PW-1:0]   occ_b_nx, occ_a_nx;

   // The swapped lattice is seen by substituting the two swapped entries.
   always_comb begin
      if (tag.addr == a_addr) begin
         aft = sb;
      end else if (tag.addr == b_addr) begin
         aft = sa;
      end else begin
         aft = rd_data;
      end
      occ_b_nx = occ_b_ff + PW'(rd_data != SPC_EMPTY);
      occ_a_nx = occ_a_ff + PW'(aft != SPC_EMPTY);
   end

   always_ff @(posedge clock) begin
      if (clr) begin
         sum_b_ff <= '0;
         sum_a_ff <= '0;
      end else if (tag.valid) begin
         if (tag.first) begin
            cen_b_ff <= rd_data;
            cen_a_ff <= aft;
            occ_b_ff <= '0;
            occ_a_ff <= '0;
         end else if (tag.last) begin
            sum_b_ff <= sum_b_ff + SUMW'(site_energy(cen_b_ff, occ_b_nx));
            sum_a_ff <= sum_a_ff + SUMW'(site_energy(cen_a_ff, occ_a_nx));
         end else begin
            occ_b_ff <= occ_b_nx;
            occ_a_ff <= occ_a_nx;
         end
      end
   end

   assign sum_before = sum_b_ff;
   assign sum_after  = sum_a_ff;

endmodule

[hw/rtl/lattice_swap_energy_delta.sv]
// Top level of the lattice swap energy block: sequencer, memory and accumulator.
// Depends on lsed_pkg, lsed_store, lsed_accum and assert_macros.svh.
//
//   channel | direction | payload  | transaction
//   req_    | in        | req_type | lattice write or swap query
//   rsp_    | out       | rsp_type | energy change of one query
//
// After reset a clearing pass writes every one of the 4096 sites to empty, one
// per cycle; req_ready stays low until it ends. A query runs from its accept
// through the states that read both sites, 98 streamed reads (14 sites times 7),
// a drain and the finish. A query with direction six or seven goes straight to
// finish, and one with equal species goes there after the check of both sites.
// The result register frees the input while a result waits; only the finish
// cycle holds while an earlier result is still not taken.
`include "assert_macros.svh"
module lattice_swap_energy_delta import lsed_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type       state_ff, state_in;
   coord_type       cur_ff, cur_in, par_ff, par_in;
   addr_type        a_addr_ff, a_addr_in, b_addr_ff, b_addr_in;
   spc_type         sa_ff, sa_in, sb_ff, sb_in;
   logic            skip_ff, skip_in;
   logic            side_ff, side_in;
   logic [PW-1:0]   kpos_ff, kpos_in, jpos_ff, jpos_in;
   tag_type         tag_ff, tag_in;
   addr_type        clr_cnt_ff, clr_cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic            wr_en;
   addr_type        wr_addr;
   spc_type         wr_data;
   addr_type        rd_addr;
   spc_type         rd_data;
   logic            acc_clr;
   logic [SUMW-1:0] sum_before, sum_after;
   coord_type       req_crd, calc_crd;
   logic            accept;

   lsed_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lsed_accum u_accum (
      .clock      (clock),
      .clr        (acc_clr),
      .tag        (tag_ff),
      .rd_data    (rd_data),
      .a_addr     (a_addr_ff),
      .b_addr     (b_addr_ff),
      .sa         (sa_ff),
      .sb         (sb_ff),
      .sum_before (sum_before),
      .sum_after  (sum_after)
   );

   assign req_crd  = '{outer: req_data.coord_outer, middle: req_data.coord_middle,
                       inner: req_data.coord_inner};
   // Site under evaluation: the center of a cluster (kpos) around site a or b,
   // then the read position around that center (jpos).
   assign calc_crd = pos_coord(pos_coord(side_ff ? par_ff : cur_ff, kpos_ff), jpos_ff);
   assign accept   = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      par_in       = par_ff;
      a_addr_in    = a_addr_ff;
      b_addr_in    = b_addr_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      skip_in      = skip_ff;
      side_in      = side_ff;
      kpos_in      = kpos_ff;
      jpos_in      = jpos_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = site_addr(req_crd);
      wr_data      = req_data.species;
      rd_addr      = site_addr(calc_crd);
      acc_clr      = 1'b0;
      tag_in       = '{valid: 1'b0, first: (jpos_ff == '0), last: (jpos_ff == POS_LAST),
                       addr: site_addr(calc_crd)};

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = SPC_EMPTY;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(SITES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (req_data.command == CMD_WRITE) begin
                  wr_en = 1'b1;
               end else begin
                  cur_in    = req_crd;
                  par_in    = nbr(req_crd, req_data.direction);
                  a_addr_in = site_addr(req_crd);
                  b_addr_in = site_addr(nbr(req_crd, req_data.direction));
                  if (req_data.direction > DIR_OUT_UP) begin
                     skip_in  = 1'b1;
                     state_in = ST_FIN;
                  end else begin
                     skip_in  = 1'b0;
                     state_in = ST_RD_A;
                  end
               end
            end
         end
         ST_RD_A: begin
            rd_addr  = a_addr_ff;
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            rd_addr  = b_addr_ff;
            sa_in    = rd_data;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            sb_in = rd_data;
            if (sa_ff == rd_data) begin
               skip_in  = 1'b1;
               state_in = ST_FIN;
            end else begin
               acc_clr  = 1'b1;
               side_in  = 1'b0;
               kpos_in  = '0;
               jpos_in  = '0;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            tag_in.valid = 1'b1;
            if (jpos_ff == POS_LAST) begin
               jpos_in = '0;
               if (kpos_ff == POS_LAST) begin
                  kpos_in = '0;
                  side_in = 1'b1;
                  if (side_ff) begin
                     state_in = ST_DRAIN;
                  end
               end else begin
                  kpos_in = kpos_ff + PW'(1);
               end
            end else begin
               jpos_in = jpos_ff + PW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.skipped       = skip_ff;
               rsp_data_in.energy_change = skip_ff ? '0 :
                  $signed({1'b0, sum_after}) - $signed({1'b0, sum_before});
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      par_ff      <= par_in;
      a_addr_ff   <= a_addr_in;
      b_addr_ff   <= b_addr_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      skip_ff     <= skip_in;
      side_ff     <= side_in;
      kpos_ff     <= kpos_in;
      jpos_ff     <= jpos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // No request is taken while the clearing pass still runs.
   `LSED_ASSERT_IMP(a_no_req_in_clear, state_ff == ST_CLEAR, !req_ready)
   // A skipped result never carries a nonzero change.
   `LSED_ASSERT_IMP(a_skip_zero, rsp_valid_ff && rsp_data_ff.skipped,
                    rsp_data_ff.energy_change == '0)
   // The sweep streams reads only while computing; the registered tag follows in the next cycle.
   `LSED_ASSERT_NXT(a_tag_follows_calc, state_ff == ST_CALC, tag_ff.valid)
   // The computation ends with the drain cycle, which always leads to finish.
   `LSED_ASSERT_NXT(a_drain_to_fin, state_ff == ST_DRAIN, state_ff == ST_FIN)

endmodule
